FILE: hdl/ihg_pkg.sv
// Shared types, constants and checksum helpers for the ICMP/IPv4 header generator.
package ihg_pkg;

  // Configuration register indexes
  localparam logic [2:0] CfgSrcAddr  = 3'd0;
  localparam logic [2:0] CfgDstAddr  = 3'd1;
  localparam logic [2:0] CfgMsgType  = 3'd2;
  localparam logic [2:0] CfgMsgCode  = 3'd3;
  localparam logic [2:0] CfgEchoId   = 3'd4;

  // ICMP types with special header handling
  localparam logic [7:0] IcmpEchoReply = 8'd0;
  localparam logic [7:0] IcmpEchoReq   = 8'd8;
  localparam logic [7:0] IcmpTsReq     = 8'd13;
  localparam logic [7:0] IcmpTsReply   = 8'd14;
  localparam logic [7:0] IcmpInfoReq   = 8'd15;
  localparam logic [7:0] IcmpInfoReply = 8'd16;

  // Fixed header fields
  localparam logic [15:0] IpVerIhlTos  = 16'h4500;
  localparam logic [15:0] IpTtlProto   = 16'hFF01;
  localparam logic [17:0] HdrLenShort  = 18'd28;
  localparam logic [17:0] HdrLenTstamp = 18'd40;
  localparam logic [16:0] LenMax       = 17'h1FFFF;
  localparam logic [3:0]  LastIdxShort = 4'd6;
  localparam logic [3:0]  LastIdxTs    = 4'd9;

  // Word indexes of the header sequence
  localparam logic [3:0] WordVerLen   = 4'd0;
  localparam logic [3:0] WordId       = 4'd1;
  localparam logic [3:0] WordTtl      = 4'd2;
  localparam logic [3:0] WordSrc      = 4'd3;
  localparam logic [3:0] WordDst      = 4'd4;
  localparam logic [3:0] WordIcmpType = 4'd5;
  localparam logic [3:0] WordIcmpId   = 4'd6;

  // One packet's worth of header parameters, captured on the last payload word
  typedef struct packed {
    logic [15:0] total_len;
    logic        len_err;
    logic [15:0] pkt_id;
    logic [15:0] psum;
    logic        tstamp;
    logic        seq;
  } job_t;

  // End-around carry fold of a sum no larger than 0x1FFFE
  function automatic logic [15:0] fold17(input logic [16:0] s);
    fold17 = s[15:0] + {15'b0, s[16]};
  endfunction

  // Byte swap of a 16-bit ones'-complement value
  function automatic logic [15:0] swap16(input logic [15:0] v);
    swap16 = {v[7:0], v[15:8]};
  endfunction

endpackage

FILE: hdl/ihg_hdr_emit.sv
// Header word sequencer: checksums, word select and output register.
module ihg_hdr_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  ihg_pkg::job_t      job_i,
  input  logic [31:0]        src_addr_i,
  input  logic [31:0]        dst_addr_i,
  input  logic [7:0]         msg_type_i,
  input  logic [7:0]         msg_code_i,
  input  logic [15:0]        echo_id_i,
  output logic               job_done_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o,  // header_word[31:0]
  output logic               m_axis_tlast_o,  // final_word
  output logic               m_axis_tuser_o   // length_error
);
  import ihg_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic [3:0]  last_idx;
  logic        out_load;
  logic [18:0] ip_sum_raw;
  logic [16:0] ip_sum_part;
  logic [15:0] ip_csum;
  logic [17:0] icmp_sum_raw;
  logic [16:0] icmp_sum_part;
  logic [15:0] icmp_csum;
  logic [15:0] seq_id;
  logic [15:0] seq_num;
  logic [31:0] word;
  logic        valid_q;
  logic [31:0] data_q;
  logic        last_q;
  logic        err_q;

  assign last_idx = job_i.tstamp ? LastIdxTs : LastIdxShort;
  assign out_load = job_valid_i && (!valid_q || m_axis_tready_i);
  assign job_done_o = out_load && (idx_q == last_idx);

  // IP header checksum over the eight nonzero fixed and variable halves
  assign ip_sum_raw = {3'b0, IpVerIhlTos} + {3'b0, job_i.total_len} + {3'b0, job_i.pkt_id}
                    + {3'b0, IpTtlProto} + {3'b0, src_addr_i[31:16]}
                    + {3'b0, src_addr_i[15:0]} + {3'b0, dst_addr_i[31:16]}
                    + {3'b0, dst_addr_i[15:0]};
  assign ip_sum_part = {1'b0, ip_sum_raw[15:0]} + {14'b0, ip_sum_raw[18:16]};
  assign ip_csum = ~fold17(ip_sum_part);

  // ICMP checksum: payload sum plus header, timestamp words are zero
  assign seq_id  = job_i.seq ? echo_id_i : 16'h0000;
  assign seq_num = job_i.seq ? job_i.pkt_id : 16'h0000;
  assign icmp_sum_raw = {2'b0, job_i.psum} + {2'b0, msg_type_i, msg_code_i}
                      + {2'b0, seq_id} + {2'b0, seq_num};
  assign icmp_sum_part = {1'b0, icmp_sum_raw[15:0]} + {15'b0, icmp_sum_raw[17:16]};
  assign icmp_csum = ~fold17(icmp_sum_part);

  // Select the word for the current position
  always_comb begin
    case (idx_q)
      WordVerLen:   word = {IpVerIhlTos, job_i.total_len};
      WordId:       word = {job_i.pkt_id, 16'h0000};
      WordTtl:      word = {IpTtlProto, ip_csum};
      WordSrc:      word = src_addr_i;
      WordDst:      word = dst_addr_i;
      WordIcmpType: word = {msg_type_i, msg_code_i, icmp_csum};
      WordIcmpId:   word = {seq_id, seq_num};
      default:      word = 32'h0000_0000;
    endcase
  end

  // Advance through the words of the active job
  always_comb begin
    idx_d = idx_q;
    if (out_load) begin
      idx_d = (idx_q == last_idx) ? 4'd0 : idx_q + 4'd1;
    end
  end

  // Hold the word until taken, load the next one as the slot frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 4'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (out_load) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      data_q <= word;
      last_q <= (idx_q == last_idx);
      err_q  <= job_i.len_err;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = err_q;

  // Position never runs past the end of the active header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (idx_q <= last_idx))
    else $error("header word index past end of header");

  // Position returns to the start whenever no job is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_i |-> (idx_q == 4'd0))
    else $error("header word index left mid-header without a job");

  // A stalled header word stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled header word dropped or changed");

endmodule

FILE: hdl/icmp_ipv4_header_generator.sv
// Top level of the ICMP-over-IPv4 header generator.
// Usage:
//   Payload words enter on the s_axis channel, one 32-bit big-endian word per
//   request with its valid-byte count in tdata[34:32] and tlast on the final
//   word. The words are summed and counted but not forwarded; the payload
//   travels past this block on its own path.
//   On each last word the block emits the IPv4 header followed by the ICMP
//   header on the m_axis channel: 7 words, or 10 for timestamp types. tlast
//   marks the final header word, tuser flags a total length above 65535.
//   Payload words are taken one per cycle. Headers go out one word per cycle
//   through a two-deep job queue (active, pending), so payload of the next
//   packet keeps flowing while a header is sent; tready drops only while a
//   second finished packet waits behind the active one.
//   The last payload word is registered into the job queue, and from there the
//   first header word is loaded into the output register. Sustained rate is set
//   by the output port: one header word per cycle while the receiver is ready.
//   When the receiver stalls, the output word holds and the queue fills.
//   The cfg channel is always ready; registers are to be written only while idle, which the block does not enforce.
//   Reset clears the sums, the queue and the registers and sets the IP id to 1.
module icmp_ipv4_header_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // payload_word[31:0], valid_bytes[34:32], zero fill
  input  logic        s_axis_tlast_i,  // end_of_payload
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // header_word[31:0]
  output logic        m_axis_tlast_o,  // final_word
  output logic        m_axis_tuser_o   // length_error
);
  import ihg_pkg::*;

  logic [31:0] src_addr_q;
  logic [31:0] dst_addr_q;
  logic [7:0]  msg_type_q;
  logic [7:0]  msg_code_q;
  logic [15:0] echo_id_q;

  logic [15:0] psum_q, psum_d;
  logic [16:0] plen_q, plen_d;
  logic [15:0] pkt_id_q;

  logic        s_fire;
  logic        job_new;
  logic [2:0]  nv;
  logic [31:0] masked;
  logic [15:0] word_sum;
  logic [15:0] contrib;
  logic [17:0] len_sum;
  logic [17:0] total;
  logic        tstamp;
  logic        seq;
  job_t        job_in;

  logic        act_valid_q;
  job_t        act_q;
  logic        pend_valid_q;
  job_t        pend_q;
  logic        act_done;
  logic        act_free;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !pend_valid_q;
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign job_new = s_fire && s_axis_tlast_i;

  // Clamp the count and drop the bytes past it
  assign nv = (s_axis_tdata_i[34:32] > 3'd4) ? 3'd4 : s_axis_tdata_i[34:32];
  always_comb begin
    masked = s_axis_tdata_i[31:0];
    if (nv < 3'd4) masked[7:0]   = 8'h00;
    if (nv < 3'd3) masked[15:8]  = 8'h00;
    if (nv < 3'd2) masked[23:16] = 8'h00;
    if (nv < 3'd1) masked[31:24] = 8'h00;
  end

  // Sum the word; swap when it starts at an odd byte offset
  assign word_sum = fold17({1'b0, masked[31:16]} + {1'b0, masked[15:0]});
  assign contrib  = plen_q[0] ? swap16(word_sum) : word_sum;
  assign psum_d   = fold17({1'b0, psum_q} + {1'b0, contrib});

  // Count bytes, saturating
  assign len_sum = {1'b0, plen_q} + {15'b0, nv};
  assign plen_d  = (len_sum > {1'b0, LenMax}) ? LenMax : len_sum[16:0];

  // Build the header job for this packet
  assign tstamp = (msg_type_q == IcmpTsReq) || (msg_type_q == IcmpTsReply);
  assign seq    = tstamp || (msg_type_q == IcmpEchoReply) || (msg_type_q == IcmpEchoReq)
               || (msg_type_q == IcmpInfoReq) || (msg_type_q == IcmpInfoReply);
  assign total  = {1'b0, plen_d} + (tstamp ? HdrLenTstamp : HdrLenShort);
  always_comb begin
    job_in.total_len = total[15:0];
    job_in.len_err   = (total[17:16] != 2'b00);
    job_in.pkt_id    = pkt_id_q;
    job_in.psum      = psum_d;
    job_in.tstamp    = tstamp;
    job_in.seq       = seq;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q <= 32'h0;
      dst_addr_q <= 32'h0;
      msg_type_q <= 8'h0;
      msg_code_q <= 8'h0;
      echo_id_q  <= 16'h0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSrcAddr: src_addr_q <= cfg_data_i;
        CfgDstAddr: dst_addr_q <= cfg_data_i;
        CfgMsgType: msg_type_q <= cfg_data_i[7:0];
        CfgMsgCode: msg_code_q <= cfg_data_i[7:0];
        CfgEchoId:  echo_id_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Running sum, length and IP id; on the last word the sum and length clear and the id steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q   <= 16'h0;
      plen_q   <= 17'h0;
      pkt_id_q <= 16'h1;
    end else if (s_fire) begin
      if (s_axis_tlast_i) begin
        psum_q   <= 16'h0;
        plen_q   <= 17'h0;
        pkt_id_q <= (pkt_id_q == 16'hFFFF) ? 16'h1 : pkt_id_q + 16'h1;
      end else begin
        psum_q <= psum_d;
        plen_q <= plen_d;
      end
    end
  end

  // Two-deep job queue feeding the header sequencer
  assign act_free = !act_valid_q || act_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (act_free) begin
      if (pend_valid_q) begin
        act_valid_q  <= 1'b1;
        pend_valid_q <= job_new;
      end else begin
        act_valid_q  <= job_new;
        pend_valid_q <= 1'b0;
      end
    end else if (job_new) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_free) begin
      if (pend_valid_q) begin
        act_q <= pend_q;
        if (job_new) pend_q <= job_in;
      end else if (job_new) begin
        act_q <= job_in;
      end
    end else if (job_new) begin
      pend_q <= job_in;
    end
  end

  ihg_hdr_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (act_valid_q),
    .job_i           (act_q),
    .src_addr_i      (src_addr_q),
    .dst_addr_i      (dst_addr_q),
    .msg_type_i      (msg_type_q),
    .msg_code_i      (msg_code_q),
    .echo_id_i       (echo_id_q),
    .job_done_o      (act_done),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // A pending job never sits behind an empty active slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> act_valid_q)
    else $error("pending header job without an active one");

  // A last payload word always leaves a header job queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_new |=> act_valid_q)
    else $error("last payload word produced no header job");

  // The IP id skips zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_id_q != 16'h0)
    else $error("IP id reached zero");

endmodule

FILE: sim/tb_icmp_ipv4_header_generator.sv
// Testbench: payload stream in, IPv4/ICMP header words checked against a local predictor.
module tb_icmp_ipv4_header_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import ihg_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReported = 10;

  // ICMP types outside the sequenced set
  localparam logic [7:0] IcmpDestUnreach = 8'd3;
  localparam logic [7:0] IcmpTypeMax     = 8'hFF;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;
  typedef enum logic {RowWord, RowReg} row_kind_e;

  // One directed row: a payload word or a register write
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
    logic        typed;
    logic [31:0] w0;
    logic        err;
  } stim_row_t;

  typedef struct {
    logic [31:0] word;
    logic        last;
    logic        err;
  } hdr_word_t;

  localparam int unsigned NumRows = 31;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // empty and full-word packets right after reset
    '{RowWord, 3'd0, 32'h00000000, 3'd0, 1'b1, 1'b1, 32'h4500001C, 1'b0},
    '{RowWord, 3'd0, 32'hFFFFFFFF, 3'd4, 1'b1, 1'b1, 32'h45000020, 1'b0},
    // counts above four
    '{RowWord, 3'd0, 32'h12345678, 3'd7, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'hA5A5A5A5, 3'd5, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'hDEADBEEF, 3'd6, 1'b1, 1'b1, 32'h45000028, 1'b0},
    // short words in the middle, odd offsets, a word with no valid bytes
    '{RowWord, 3'd0, 32'hAB000000, 3'd1, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'hCDEF0000, 3'd2, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'h01020300, 3'd3, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'hFFFFFFFF, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'h80000001, 3'd4, 1'b1, 1'b1, 32'h45000026, 1'b0},
    // odd final byte, single byte
    '{RowWord, 3'd0, 32'h11223344, 3'd3, 1'b1, 1'b1, 32'h4500001F, 1'b0},
    '{RowWord, 3'd0, 32'h55667788, 3'd1, 1'b1, 1'b1, 32'h4500001D, 1'b0},
    // register extremes, then every kind of type
    '{RowReg, CfgSrcAddr, 32'hFFFFFFFF, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgDstAddr, 32'hFFFFFFFF, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgEchoId, 32'h0000FFFF, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgMsgCode, 32'h000000FF, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgMsgType, {24'h0, IcmpEchoReq}, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'h00010203, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgMsgType, {24'h0, IcmpTsReq}, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'h00000000, 3'd0, 1'b1, 1'b1, 32'h45000028, 1'b0},
    '{RowReg, CfgMsgType, {24'h0, IcmpTsReply}, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'hFEDCBA98, 3'd2, 1'b1, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgMsgType, {24'h0, IcmpInfoReq}, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'h7F7F7F7F, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgMsgType, {24'h0, IcmpInfoReply}, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'h0F0E0D0C, 3'd3, 1'b1, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgMsgType, {24'h0, IcmpDestUnreach}, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'hC0A80001, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgMsgType, {24'h0, IcmpTypeMax}, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{RowWord, 3'd0, 32'h00FF00FF, 3'd1, 1'b1, 1'b0, 32'h0, 1'b0},
    '{RowReg, CfgMsgType, {24'h0, IcmpEchoReply}, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic [39:0] in_data;
  logic        in_last;
  logic        out_ready;
  logic        cfg_ready_o;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  // Predictor copy of registers and running state
  logic [31:0] cfg_src;
  logic [31:0] cfg_dst;
  logic [7:0]  cfg_type;
  logic [7:0]  cfg_code;
  logic [15:0] cfg_ident;
  logic [15:0] run_sum;
  logic [16:0] run_len;
  logic [15:0] next_ip_id;

  hdr_word_t   hdr_words_due[$];
  idle_mode_e  idle_mode;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  bit          hold_req;

  icmp_ipv4_header_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // End-around carry add of two 16-bit values
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IdleSender: return $urandom_range(99, 0) < 76;
      IdleBoth:   return $urandom_range(99, 0) < 16;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IdleReceiver: return $urandom_range(99, 0) < 76;
      IdleBoth:     return $urandom_range(99, 0) < 16;
      default:      return 1'b0;
    endcase
  endfunction

  // Fold one accepted payload word into the sum; on the last word queue the header
  task automatic absorb_payload(input logic [31:0] word, input logic [2:0] nb,
                                input logic last, input logic typed,
                                input logic [31:0] w0, input logic err);
    int unsigned nvalid;
    int unsigned grown;
    int unsigned nwords;
    int          k;
    logic [7:0]  b;
    logic [17:0] total;
    logic        tstamp;
    logic        sequenced;
    logic [15:0] s;
    logic [31:0] hw [10];
    hdr_word_t   r;
    nvalid = (nb > 3'd4) ? 4 : nb;
    for (k = 0; k < nvalid; k++) begin
      b = word[31 - 8 * k -: 8];
      run_sum = oc_add(run_sum, (run_len[0] ^ k[0]) ? {8'h00, b} : {b, 8'h00});
    end
    grown = run_len + nvalid;
    run_len = (grown > LenMax) ? LenMax : grown[16:0];
    if (!last) return;

    tstamp = (cfg_type == IcmpTsReq) || (cfg_type == IcmpTsReply);
    sequenced = tstamp || (cfg_type == IcmpEchoReply) || (cfg_type == IcmpEchoReq)
                || (cfg_type == IcmpInfoReq) || (cfg_type == IcmpInfoReply);
    nwords = tstamp ? 10 : 7;
    total = (tstamp ? 18'd40 : 18'd28) + {1'b0, run_len};

    // IP header with its checksum
    hw[0] = {IpVerIhlTos, total[15:0]};
    hw[1] = {next_ip_id, 16'h0000};
    hw[2] = {IpTtlProto, 16'h0000};
    hw[3] = cfg_src;
    hw[4] = cfg_dst;
    s = 16'h0000;
    for (k = 0; k < 5; k++) s = oc_add(oc_add(s, hw[k][31:16]), hw[k][15:0]);
    hw[2][15:0] = ~s;

    // ICMP header, checksum over header and payload
    hw[5] = {cfg_type, cfg_code, 16'h0000};
    hw[6] = sequenced ? {cfg_ident, next_ip_id} : 32'h0;
    hw[7] = 32'h0;
    hw[8] = 32'h0;
    hw[9] = 32'h0;
    s = run_sum;
    for (k = 5; k < nwords; k++) s = oc_add(oc_add(s, hw[k][31:16]), hw[k][15:0]);
    hw[5][15:0] = ~s;

    for (k = 0; k < nwords; k++) begin
      r.word = (typed && k == 0) ? w0 : hw[k];
      r.last = (k == nwords - 1);
      r.err  = typed ? err : (total > 18'h0FFFF);
      hdr_words_due.push_back(r);
    end
    run_sum = 16'h0000;
    run_len = 17'h0;
    next_ip_id = (next_ip_id == 16'hFFFF) ? 16'h0001 : next_ip_id + 16'h0001;
  endtask

  // Offer one payload word, keeping valid high between back-to-back requests
  task automatic send_word(input logic [31:0] word, input logic [2:0] nb, input logic last,
                           input logic typed = 1'b0, input logic [31:0] w0 = 32'h0,
                           input logic err = 1'b0);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {5'b0, nb, word};
    in_last  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_payload(word, nb, last, typed, w0, err);
  endtask

  // Stop offering and wait until every queued header word has arrived
  task automatic drain_headers();
    in_valid <= 1'b0;
    while (hdr_words_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CfgSrcAddr: cfg_src   = val;
      CfgDstAddr: cfg_dst   = val;
      CfgMsgType: cfg_type  = val[7:0];
      CfgMsgCode: cfg_code  = val[7:0];
      CfgEchoId:  cfg_ident = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] src, input logic [31:0] dst,
                            input logic [7:0] mtype, input logic [7:0] mcode,
                            input logic [15:0] ident);
    write_reg(CfgSrcAddr, src);
    write_reg(CfgDstAddr, dst);
    write_reg(CfgMsgType, {24'h0, mtype});
    write_reg(CfgMsgCode, {24'h0, mcode});
    write_reg(CfgEchoId, {16'h0, ident});
  endtask

  task automatic random_config();
    logic [7:0] mtype;
    case ($urandom_range(7, 0))
      0: mtype = IcmpEchoReply;
      1: mtype = IcmpEchoReq;
      2: mtype = IcmpTsReq;
      3: mtype = IcmpTsReply;
      4: mtype = IcmpInfoReq;
      5: mtype = IcmpInfoReply;
      6: mtype = IcmpDestUnreach;
      default: mtype = 8'($urandom);
    endcase
    set_config($urandom, $urandom, mtype, 8'($urandom), 16'($urandom));
  endtask

  // Mostly full middle words and a short last word; now and then a broken count
  task automatic send_random_packet(output int unsigned n_sent);
    int unsigned n_words;
    int unsigned w;
    logic [2:0]  nb;
    n_words = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
    for (w = 0; w < n_words; w++) begin
      if (w + 1 == n_words)
        nb = ($urandom_range(7, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
      else
        nb = ($urandom_range(7, 0) == 0) ? 3'($urandom_range(7, 0)) : 3'd4;
      send_word($urandom, nb, w + 1 == n_words);
    end
    n_sent = n_words;
  endtask

  task automatic run_random_phase(input idle_mode_e mode, input int unsigned n_items);
    int unsigned sent;
    int unsigned got;
    idle_mode = mode;
    sent = 0;
    while (sent < n_items) begin
      send_random_packet(got);
      sent += got;
    end
    drain_headers();
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("mismatch: %s", msg);
  endtask

  // Receiver: check accepted header words, then choose the next ready
  initial begin : header_sink
    int unsigned hold_left;
    logic        ready_nxt;
    hdr_word_t   exp_w;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && out_ready) begin
        if (hdr_words_due.size() == 0) begin
          note_mismatch($sformatf("unexpected header word %h", m_axis_tdata_o));
        end else begin
          exp_w = hdr_words_due.pop_front();
          if (m_axis_tdata_o !== exp_w.word)
            note_mismatch($sformatf("header word exp %h got %h", exp_w.word, m_axis_tdata_o));
          if (m_axis_tlast_o !== exp_w.last)
            note_mismatch($sformatf("final_word exp %b got %b on %h",
                                    exp_w.last, m_axis_tlast_o, exp_w.word));
          if (m_axis_tuser_o !== exp_w.err)
            note_mismatch($sformatf("length_error exp %b got %b on %h",
                                    exp_w.err, m_axis_tuser_o, exp_w.word));
        end
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = !receiver_stalls();
      end
      out_ready <= ready_nxt;
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned k;
    rst_ni     <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CfgSrcAddr;
    cfg_data   <= 32'h0;
    in_valid   <= 1'b0;
    in_data    <= 40'h0;
    in_last    <= 1'b0;
    out_ready  <= 1'b0;
    cfg_src    = 32'h0;
    cfg_dst    = 32'h0;
    cfg_type   = 8'h00;
    cfg_code   = 8'h00;
    cfg_ident  = 16'h0000;
    run_sum    = 16'h0000;
    run_len    = 17'h0;
    next_ip_id = 16'h0001;
    mismatches = 0;
    hold_req   = 1'b0;
    idle_mode  = IdleNone;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; registers change only once the headers are out
    for (r = 0; r < NumRows; r++) begin
      if (DirectedRows[r].kind == RowReg) begin
        drain_headers();
        write_reg(DirectedRows[r].reg_idx, DirectedRows[r].data);
      end else begin
        send_word(DirectedRows[r].data, DirectedRows[r].nbytes, DirectedRows[r].last,
                  DirectedRows[r].typed, DirectedRows[r].w0, DirectedRows[r].err);
      end
    end
    drain_headers();

    // Back-pressure: hold the receiver off while short packets keep coming
    set_config($urandom, $urandom, IcmpTsReq, 8'($urandom), 16'($urandom));
    hold_req = 1'b1;
    for (k = 0; k < 12; k++) send_word($urandom, 3'($urandom_range(4, 0)), 1'b1);
    drain_headers();

    // Random phases under each idling pattern
    set_config(32'hFFFFFFFF, 32'hFFFFFFFF, IcmpTypeMax, 8'hFF, 16'hFFFF);
    run_random_phase(IdleNone, 58);
    set_config(32'h0, 32'h0, IcmpTsReq, 8'h00, 16'h0000);
    run_random_phase(IdleSender, 58);
    random_config();
    run_random_phase(IdleReceiver, 58);
    random_config();
    run_random_phase(IdleBoth, 58);

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && hdr_words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
